// File: sv/lpei_pkg.sv
`default_nettype none

package lpei_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 8;
	localparam int OUT_W       = 24;
	localparam int DIGIT_W     = 4;

	localparam int EXT_W  = COORD_WIDTH + 1;
	localparam int LCC_W  = 2 * COORD_WIDTH + 1;
	localparam int DEN_W  = 2 * COORD_WIDTH + 2;
	localparam int ACC_W  = 3 * COORD_WIDTH + 3;
	localparam int NDIG   = (EXT_W + DIGIT_W - 1) / DIGIT_W;
	localparam int QS_W   = NDIG * DIGIT_W;
	localparam int MCNT_W = $clog2(NDIG + 1);
	localparam int DCNT_W = $clog2(OUT_W + 1);
	localparam int NUM_W  = (ACC_W + FRAC_BITS > OUT_W) ? ACC_W + FRAC_BITS : OUT_W + 1;
	localparam int HI_W   = NUM_W - OUT_W;
	localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [EXT_W-1:0]       ext_t;
	typedef logic signed [LCC_W-1:0]       lcc_t;
	typedef logic signed [DEN_W-1:0]       den_t;
	typedef logic signed [ACC_W-1:0]       acc_t;
	typedef logic signed [QS_W-1:0]        qs_t;
	typedef logic signed [OUT_W-1:0]       res_t;
	typedef logic [MCNT_W-1:0]             mcnt_t;
	typedef logic [DCNT_W-1:0]             dcnt_t;
	typedef logic [NUM_W-1:0]              num_t;
	typedef logic [CMP_W-1:0]              cmp_t;
	typedef logic [1:0]                    cfg_idx_t;

	localparam cfg_idx_t REG_LINE_X0 = 2'd0;
	localparam cfg_idx_t REG_LINE_Y0 = 2'd1;
	localparam cfg_idx_t REG_LINE_X1 = 2'd2;
	localparam cfg_idx_t REG_LINE_Y1 = 2'd3;

	typedef struct packed {
		logic start;
		logic load;
		logic sub;
		acc_t init;
		acc_t p;
		ext_t q;
	} mac_ctl_t;

	typedef struct packed {
		logic start;
		acc_t num;
		den_t den;
	} div_req_t;

endpackage

`default_nettype wire

// File: sv/lpei_if.sv
`default_nettype none

interface lpei_cfg_if;
	logic                valid;
	logic                ready;
	lpei_pkg::cfg_idx_t  index;
	lpei_pkg::coord_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface lpei_vertex_if;
	logic              valid;
	logic              ready;
	lpei_pkg::coord_t  vertex_x;
	lpei_pkg::coord_t  vertex_y;
	logic              closes_polygon;

	modport source (output valid, output vertex_x, output vertex_y, output closes_polygon,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input closes_polygon,
		output ready);
endinterface

interface lpei_cross_if;
	logic            valid;
	logic            ready;
	lpei_pkg::res_t  cross_x;
	lpei_pkg::res_t  cross_y;
	logic            run_end;

	modport source (output valid, output cross_x, output cross_y, output run_end, input ready);
	modport sink (input valid, input cross_x, input cross_y, input run_end, output ready);
endinterface

`default_nettype wire

// File: sv/lpei_mac.sv
`default_nettype none

module lpei_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  lpei_pkg::mac_ctl_t ctl,
	output lpei_pkg::acc_t     acc,
	output logic               done
);

	lpei_pkg::acc_t  acc_q;
	lpei_pkg::acc_t  p_sh_q;
	lpei_pkg::qs_t   q_sh_q;
	lpei_pkg::mcnt_t cnt_q;
	logic            sub_q;
	logic            done_q;

	logic [lpei_pkg::DIGIT_W-1:0]              dig;
	logic                                      last;
	logic signed [lpei_pkg::DIGIT_W:0]         sdig;
	logic signed [lpei_pkg::ACC_W+lpei_pkg::DIGIT_W:0] prod;

	assign dig  = q_sh_q[lpei_pkg::DIGIT_W-1:0];
	assign last = (cnt_q == lpei_pkg::mcnt_t'(1));
	// top digit carries the sign of the serial operand
	assign sdig = {last & dig[lpei_pkg::DIGIT_W-1], dig};
	assign prod = p_sh_q * sdig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= lpei_pkg::mcnt_t'(lpei_pkg::NDIG);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - lpei_pkg::mcnt_t'(1);
				done_q <= last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			p_sh_q <= ctl.p;
			q_sh_q <= lpei_pkg::qs_t'(ctl.q);
			sub_q  <= ctl.sub;
			if (ctl.load) begin
				acc_q <= ctl.init;
			end
		end else if (cnt_q != '0) begin
			if (sub_q) begin
				acc_q <= acc_q - prod[lpei_pkg::ACC_W-1:0];
			end else begin
				acc_q <= acc_q + prod[lpei_pkg::ACC_W-1:0];
			end
			p_sh_q <= p_sh_q << lpei_pkg::DIGIT_W;
			q_sh_q <= q_sh_q >> lpei_pkg::DIGIT_W;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> cnt_q == '0)
		else $error("mac started while busy");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cnt_q) == lpei_pkg::mcnt_t'(1))
		else $error("mac done without final digit");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cnt_q == '0)
		else $error("mac done while still running");

endmodule

`default_nettype wire

// File: sv/lpei_div.sv
`default_nettype none

module lpei_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lpei_pkg::div_req_t req,
	output lpei_pkg::res_t     quo,
	output logic               done
);

	localparam logic [1:0] DS_IDLE = 2'd0;
	localparam logic [1:0] DS_PREP = 2'd1;
	localparam logic [1:0] DS_ITER = 2'd2;
	localparam logic [1:0] DS_FIN  = 2'd3;

	logic [1:0]                     dstate_q;
	lpei_pkg::dcnt_t                cnt_q;
	logic                           done_q;
	logic                           neg_q;
	logic                           ovf_q;
	logic [lpei_pkg::ACC_W-1:0]     nmag_q;
	logic [lpei_pkg::DEN_W-1:0]     dmag_q;
	logic [lpei_pkg::DEN_W-1:0]     rem_q;
	logic [lpei_pkg::OUT_W-1:0]     nlo_q;
	logic [lpei_pkg::OUT_W-1:0]     q_q;
	lpei_pkg::res_t                 quo_q;

	lpei_pkg::num_t                 nfull;
	logic [lpei_pkg::HI_W-1:0]      nhi;
	lpei_pkg::cmp_t                 nhi_c;
	logic [lpei_pkg::DEN_W:0]       trial;
	logic [lpei_pkg::DEN_W:0]       diff;
	logic                           ge;
	logic [lpei_pkg::OUT_W-1:0]     lim;
	logic [lpei_pkg::OUT_W-1:0]     mag;

	assign nfull = lpei_pkg::num_t'(nmag_q) << lpei_pkg::FRAC_BITS;
	assign nhi   = nfull[lpei_pkg::NUM_W-1:lpei_pkg::OUT_W];
	assign nhi_c = lpei_pkg::cmp_t'(nhi);
	assign trial = {rem_q, nlo_q[lpei_pkg::OUT_W-1]};
	assign diff  = trial - {1'b0, dmag_q};
	assign ge    = (trial >= {1'b0, dmag_q});
	assign lim   = neg_q ? {1'b1, {(lpei_pkg::OUT_W-1){1'b0}}}
		: {1'b0, {(lpei_pkg::OUT_W-1){1'b1}}};
	assign mag   = (ovf_q || q_q > lim) ? lim : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= DS_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (dstate_q)
				DS_IDLE: begin
					if (req.start) begin
						dstate_q <= DS_PREP;
					end
				end
				DS_PREP: begin
					cnt_q    <= lpei_pkg::dcnt_t'(lpei_pkg::OUT_W);
					dstate_q <= DS_ITER;
				end
				DS_ITER: begin
					cnt_q <= cnt_q - lpei_pkg::dcnt_t'(1);
					if (cnt_q == lpei_pkg::dcnt_t'(1)) begin
						dstate_q <= DS_FIN;
					end
				end
				DS_FIN: begin
					done_q   <= 1'b1;
					dstate_q <= DS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (dstate_q)
			DS_IDLE: begin
				if (req.start) begin
					neg_q  <= req.num[lpei_pkg::ACC_W-1] ^ req.den[lpei_pkg::DEN_W-1];
					nmag_q <= req.num[lpei_pkg::ACC_W-1] ? -req.num : req.num;
					dmag_q <= req.den[lpei_pkg::DEN_W-1] ? -req.den : req.den;
				end
			end
			DS_PREP: begin
				// quotient fits the output only if the high part is below the divisor
				ovf_q <= nhi_c >= lpei_pkg::cmp_t'(dmag_q);
				rem_q <= nhi_c[lpei_pkg::DEN_W-1:0];
				nlo_q <= nfull[lpei_pkg::OUT_W-1:0];
				q_q   <= '0;
			end
			DS_ITER: begin
				rem_q <= ge ? diff[lpei_pkg::DEN_W-1:0] : trial[lpei_pkg::DEN_W-1:0];
				nlo_q <= nlo_q << 1;
				q_q   <= {q_q[lpei_pkg::OUT_W-2:0], ge};
			end
			DS_FIN: begin
				quo_q <= neg_q ? -mag : mag;
			end
		endcase
	end

	assign quo  = quo_q;
	assign done = done_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> dstate_q == DS_IDLE)
		else $error("divider started while busy");

	a_done_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(dstate_q) == DS_FIN)
		else $error("divider done out of sequence");

	a_iter_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		dstate_q == DS_ITER |-> cnt_q != '0)
		else $error("divider iterating with empty count");

endmodule

`default_nettype wire

// File: sv/line_polygon_edge_intersect.sv
// line_polygon_edge_intersect: crossings of a fixed cutting line with a streamed polygon.
// cfg: write-only register port, always ready; index 0..3 selects line_x0, line_y0,
//   line_x1, line_y1. Write only while the block is idle.
// vertex: one polygon vertex per item; closes_polygon marks the last vertex, whose
//   item also tests the closing edge back to the first vertex.
// crossing: zero, one or two items per vertex, in edge order; run_end marks the
//   last one caused by a vertex. Edges that touch or run parallel give nothing.
// Schedule: one vertex at a time. Each product goes through a 4-bit digit-serial
//   multiplier and each coordinate through a one-bit-per-cycle divider. A vertex
//   first sets up the line constant; each edge then tests both end points against
//   the line, and only an edge whose ends lie on opposite sides goes on to its
//   denominator and, if that is nonzero, to both numerators and both divisions.
// The vertex channel is ready only between vertices; a result waiting in the output
//   register does not hold back the next vertex, but a stalled receiver holds the
//   block in drain until each result of the vertex has moved into the output register.
// Reset: line (0,0)-(1,0), no vertex seen, output empty.

`default_nettype none

module line_polygon_edge_intersect (
	input  logic                 clk,
	input  logic                 arst_n,
	lpei_cfg_if.sink             cfg,
	lpei_vertex_if.sink          vertex,
	lpei_cross_if.source         crossing
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_LCC0  = 5'd1;
	localparam logic [4:0] ST_LCC1  = 5'd2;
	localparam logic [4:0] ST_SA0   = 5'd3;
	localparam logic [4:0] ST_SA1   = 5'd4;
	localparam logic [4:0] ST_SB0   = 5'd5;
	localparam logic [4:0] ST_SB1   = 5'd6;
	localparam logic [4:0] ST_C0    = 5'd7;
	localparam logic [4:0] ST_C1    = 5'd8;
	localparam logic [4:0] ST_DEN0  = 5'd9;
	localparam logic [4:0] ST_DEN1  = 5'd10;
	localparam logic [4:0] ST_XN0   = 5'd11;
	localparam logic [4:0] ST_XN1   = 5'd12;
	localparam logic [4:0] ST_DIVX  = 5'd13;
	localparam logic [4:0] ST_YN0   = 5'd14;
	localparam logic [4:0] ST_YN1   = 5'd15;
	localparam logic [4:0] ST_DIVY  = 5'd16;
	localparam logic [4:0] ST_DRAIN = 5'd17;

	logic [4:0]        state_q;
	logic              phase_q;
	lpei_pkg::coord_t  lx0_q, ly0_q, lx1_q, ly1_q;
	lpei_pkg::coord_t  first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic              have_prev_q;
	logic              pend1_q, pend2_q;
	lpei_pkg::coord_t  vx_q, vy_q;
	lpei_pkg::coord_t  ax_q, ay_q, bx_q, by_q;
	lpei_pkg::lcc_t    lcc_q;
	lpei_pkg::lcc_t    c_q;
	lpei_pkg::den_t    den_q;
	logic              sa_neg_q, sa_pos_q;
	lpei_pkg::res_t    rx_q;
	lpei_pkg::res_t    res_x_q [2];
	lpei_pkg::res_t    res_y_q [2];
	logic [1:0]        nres_q;
	logic              didx_q;
	logic              out_valid_q;
	lpei_pkg::res_t    out_x_q, out_y_q;
	logic              out_end_q;

	lpei_pkg::ext_t     laa, lbb, ea, eb;
	lpei_pkg::mac_ctl_t mac_ctl;
	lpei_pkg::acc_t     mac_acc;
	logic               mac_done;
	lpei_pkg::div_req_t div_req;
	lpei_pkg::res_t     div_quo;
	logic               div_done;
	logic               in_acc;
	logic               step_done;
	logic               sb_neg, sb_pos, opposite, den_zero;
	logic               advance;
	logic               load_e2;
	logic               out_free;
	logic               load_out;
	logic               last_item;

	assign laa = lpei_pkg::ext_t'(ly0_q) - lpei_pkg::ext_t'(ly1_q);
	assign lbb = lpei_pkg::ext_t'(lx1_q) - lpei_pkg::ext_t'(lx0_q);
	assign ea  = lpei_pkg::ext_t'(ay_q) - lpei_pkg::ext_t'(by_q);
	assign eb  = lpei_pkg::ext_t'(bx_q) - lpei_pkg::ext_t'(ax_q);

	assign cfg.ready    = 1'b1;
	assign vertex.ready = (state_q == ST_IDLE);
	assign in_acc       = vertex.valid && (state_q == ST_IDLE);

	// operand schedule of the shared multiplier
	always_comb begin
		mac_ctl       = '0;
		mac_ctl.start = !phase_q;
		unique case (state_q)
			ST_LCC0: begin
				mac_ctl.load = 1'b1;
				mac_ctl.p    = lpei_pkg::acc_t'(lx0_q);
				mac_ctl.q    = lpei_pkg::ext_t'(ly1_q);
			end
			ST_LCC1: begin
				mac_ctl.sub = 1'b1;
				mac_ctl.p   = lpei_pkg::acc_t'(lx1_q);
				mac_ctl.q   = lpei_pkg::ext_t'(ly0_q);
			end
			ST_SA0: begin
				mac_ctl.load = 1'b1;
				mac_ctl.init = lpei_pkg::acc_t'(lcc_q);
				mac_ctl.p    = lpei_pkg::acc_t'(laa);
				mac_ctl.q    = lpei_pkg::ext_t'(ax_q);
			end
			ST_SA1: begin
				mac_ctl.p = lpei_pkg::acc_t'(lbb);
				mac_ctl.q = lpei_pkg::ext_t'(ay_q);
			end
			ST_SB0: begin
				mac_ctl.load = 1'b1;
				mac_ctl.init = lpei_pkg::acc_t'(lcc_q);
				mac_ctl.p    = lpei_pkg::acc_t'(laa);
				mac_ctl.q    = lpei_pkg::ext_t'(bx_q);
			end
			ST_SB1: begin
				mac_ctl.p = lpei_pkg::acc_t'(lbb);
				mac_ctl.q = lpei_pkg::ext_t'(by_q);
			end
			ST_C0: begin
				mac_ctl.load = 1'b1;
				mac_ctl.p    = lpei_pkg::acc_t'(ax_q);
				mac_ctl.q    = lpei_pkg::ext_t'(by_q);
			end
			ST_C1: begin
				mac_ctl.sub = 1'b1;
				mac_ctl.p   = lpei_pkg::acc_t'(bx_q);
				mac_ctl.q   = lpei_pkg::ext_t'(ay_q);
			end
			ST_DEN0: begin
				mac_ctl.load = 1'b1;
				mac_ctl.p    = lpei_pkg::acc_t'(ea);
				mac_ctl.q    = lbb;
			end
			ST_DEN1: begin
				mac_ctl.sub = 1'b1;
				mac_ctl.p   = lpei_pkg::acc_t'(laa);
				mac_ctl.q   = eb;
			end
			ST_XN0: begin
				mac_ctl.load = 1'b1;
				mac_ctl.p    = lpei_pkg::acc_t'(lcc_q);
				mac_ctl.q    = eb;
			end
			ST_XN1: begin
				mac_ctl.sub = 1'b1;
				mac_ctl.p   = lpei_pkg::acc_t'(c_q);
				mac_ctl.q   = lbb;
			end
			ST_YN0: begin
				mac_ctl.load = 1'b1;
				mac_ctl.p    = lpei_pkg::acc_t'(c_q);
				mac_ctl.q    = laa;
			end
			ST_YN1: begin
				mac_ctl.sub = 1'b1;
				mac_ctl.p   = lpei_pkg::acc_t'(lcc_q);
				mac_ctl.q   = ea;
			end
			default: begin
				mac_ctl.start = 1'b0;
			end
		endcase
	end

	assign div_req.start = ((state_q == ST_DIVX) || (state_q == ST_DIVY)) && !phase_q;
	assign div_req.num   = mac_acc;
	assign div_req.den   = den_q;

	lpei_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	lpei_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign step_done = phase_q && (mac_done || div_done);
	assign sb_neg    = mac_acc[lpei_pkg::ACC_W-1];
	assign sb_pos    = !mac_acc[lpei_pkg::ACC_W-1] && (mac_acc != '0);
	assign opposite  = (sa_neg_q && sb_pos) || (sa_pos_q && sb_neg);
	assign den_zero  = (mac_acc == '0);

	// end of the line setup or of an edge: pick the next edge or drain
	assign advance = step_done && (
		(state_q == ST_LCC1) ||
		(state_q == ST_SB1 && !opposite) ||
		(state_q == ST_DEN1 && den_zero) ||
		(state_q == ST_DIVY));
	assign load_e2 = advance && !pend1_q && pend2_q;

	assign out_free  = !out_valid_q || crossing.ready;
	assign load_out  = (state_q == ST_DRAIN) && (nres_q != 2'd0) && out_free;
	assign last_item = ({1'b0, didx_q} + 2'd1) == nres_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			lx0_q       <= '0;
			ly0_q       <= '0;
			lx1_q       <= lpei_pkg::coord_t'(1);
			ly1_q       <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			pend1_q     <= 1'b0;
			pend2_q     <= 1'b0;
			nres_q      <= 2'd0;
			didx_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					lpei_pkg::REG_LINE_X0: lx0_q <= cfg.data;
					lpei_pkg::REG_LINE_Y0: ly0_q <= cfg.data;
					lpei_pkg::REG_LINE_X1: lx1_q <= cfg.data;
					lpei_pkg::REG_LINE_Y1: ly1_q <= cfg.data;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (crossing.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pend1_q  <= have_prev_q;
						pend2_q  <= vertex.closes_polygon;
						prev_x_q <= vertex.vertex_x;
						prev_y_q <= vertex.vertex_y;
						if (!have_prev_q) begin
							first_x_q <= vertex.vertex_x;
							first_y_q <= vertex.vertex_y;
						end
						have_prev_q <= !vertex.closes_polygon;
						nres_q      <= 2'd0;
						didx_q      <= 1'b0;
						phase_q     <= 1'b0;
						state_q     <= ST_LCC0;
					end
				end
				ST_DRAIN: begin
					if (nres_q == 2'd0) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						didx_q <= !didx_q;
						if (last_item) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (step_done) begin
						phase_q <= 1'b0;
						if (state_q == ST_DIVY) begin
							nres_q <= nres_q + 2'd1;
						end
						if (!advance) begin
							state_q <= state_q + 5'd1;
						end else if (pend1_q) begin
							pend1_q <= 1'b0;
							state_q <= ST_SA0;
						end else if (pend2_q) begin
							pend2_q <= 1'b0;
							state_q <= ST_SA0;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			vx_q <= vertex.vertex_x;
			vy_q <= vertex.vertex_y;
			ax_q <= prev_x_q;
			ay_q <= prev_y_q;
			bx_q <= vertex.vertex_x;
			by_q <= vertex.vertex_y;
		end
		if (load_e2) begin
			ax_q <= vx_q;
			ay_q <= vy_q;
			bx_q <= first_x_q;
			by_q <= first_y_q;
		end
		if (step_done) begin
			priority case (state_q)
				ST_LCC1: lcc_q <= mac_acc[lpei_pkg::LCC_W-1:0];
				ST_SA1: begin
					sa_neg_q <= sb_neg;
					sa_pos_q <= sb_pos;
				end
				ST_C1:   c_q   <= mac_acc[lpei_pkg::LCC_W-1:0];
				ST_DEN1: den_q <= mac_acc[lpei_pkg::DEN_W-1:0];
				ST_DIVX: rx_q  <= div_quo;
				ST_DIVY: begin
					res_x_q[nres_q[0]] <= rx_q;
					res_y_q[nres_q[0]] <= div_quo;
				end
				default: ;
			endcase
		end
		if (load_out) begin
			out_x_q   <= res_x_q[didx_q];
			out_y_q   <= res_y_q[didx_q];
			out_end_q <= last_item;
		end
	end

	assign crossing.valid   = out_valid_q;
	assign crossing.cross_x = out_x_q;
	assign crossing.cross_y = out_y_q;
	assign crossing.run_end = out_end_q;

	a_nres_max: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q != 2'd3)
		else $error("more than two crossings for one vertex");

	a_mac_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> phase_q)
		else $error("multiplier finished with nothing issued");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> phase_q && (state_q == ST_DIVX || state_q == ST_DIVY))
		else $error("divider finished outside a divide step");

endmodule

`default_nettype wire
